@@ rtl/core/point_mass_motion_step_unit_assert.svh @@
// Assertion macros for the checker module of the motion step unit.
`ifndef POINT_MASS_MOTION_STEP_UNIT_ASSERT_SVH
`define POINT_MASS_MOTION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, with reset masking
`define PMS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, with reset masking
`define PMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and saturating helpers of the motion step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [22:0] MASS_RST  = 23'd65536;
  localparam logic [15:0] SPEED_RST = 16'd1000;
  localparam logic [11:0] WIDTH_RST = 12'd1024;
  localparam logic [11:0] HEIGHT_RST = 12'd768;
  localparam logic [19:0] MU_RST    = 20'd655;
  localparam logic [19:0] NORM_RST  = 20'd65536;

  // register indexes
  localparam logic [2:0] CFG_MASS   = 3'd0;
  localparam logic [2:0] CFG_SPEED  = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_MU     = 3'd4;
  localparam logic [2:0] CFG_NORM   = 3'd5;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] num;
    logic [63:0] den;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WAIT, ST_DIVX, ST_AX, ST_AY,
    ST_SQX, ST_SQY, ST_SQS, ST_RFR, ST_FU, ST_FMU, ST_FN, ST_FDIV, ST_FACC,
    ST_VEL, ST_LX, ST_LY, ST_LL, ST_LCMP, ST_RLM, ST_LMUL, ST_LDIV, ST_LSET,
    ST_POS, ST_WALL, ST_DONE
  } state_t;

  // two's complement magnitude, full range
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed add saturating to 32 bits
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) add_sat = s[32] ? S32_MIN : S32_MAX;
    else add_sat = s[31:0];
  endfunction

  // saturating negate
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    neg_sat = (v == S32_MIN) ? S32_MAX : -v;
  endfunction

  // apply sign to an unsigned quotient, saturating to 32 bits
  function automatic logic signed [31:0] sat_div(input logic [63:0] q,
                                                 input logic neg);
    if (neg) sat_div = (q > 64'h80000000) ? S32_MIN : -(q[31:0]);
    else sat_div = (q > 64'h7FFFFFFF) ? S32_MAX : q[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pms_arith.sv @@
// ----------------------------------------------------------------------------
// pms_arith
// Shared iterative unit: 64/64 restoring divide or 64-bit integer square root,
// one bit (or bit pair) per cycle through a single subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_arith (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pms_pkg::arith_req_t req,
  output pms_pkg::arith_rsp_t      rsp
);

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  logic                busy;
  logic                done;
  pms_pkg::op_t        op;
  logic [CNT_W-1:0]    cnt;
  logic [64:0]         acc;   // remainder / radicand
  logic [63:0]         work;  // quotient / root
  logic [63:0]         aux;   // divisor / root bit

  logic [64:0] sub_a;
  logic [64:0] sub_b;
  logic [65:0] diff;
  logic        ge;

  // single shared compare-subtract
  always_comb begin
    if (op == pms_pkg::OP_DIV) begin
      sub_a = {acc[63:0], work[63]};
      sub_b = {1'b0, aux};
    end else begin
      sub_a = acc;
      sub_b = {1'b0, work + aux};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[65];
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        if (req.op == pms_pkg::OP_DIV) begin
          acc  <= '0;
          work <= req.num;
          aux  <= req.den;
          cnt  <= CNT_W'(DIV_STEPS - 1);
        end else begin
          acc  <= {1'b0, req.num};
          work <= '0;
          aux  <= 64'h4000_0000_0000_0000;
          cnt  <= CNT_W'(SQRT_STEPS - 1);
        end
      end else if (busy) begin
        if (op == pms_pkg::OP_DIV) begin
          acc  <= ge ? diff[64:0] : sub_a;
          work <= {work[62:0], ge};
        end else begin
          if (ge) begin
            acc  <= diff[64:0];
            work <= (work >> 1) + aux;
          end else begin
            work <= work >> 1;
          end
          aux <= aux >> 2;
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = work;

endmodule

`default_nettype wire

@@ rtl/core/point_mass_motion_step_unit.sv @@
// ----------------------------------------------------------------------------
// point_mass_motion_step_unit
// One Euler step of a 2-D point mass per item, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input item on s_*: forces and gravity in s_tdata, friction enable in
//    s_tuser. One result item on m_*: new position and velocity in m_tdata,
//    bounce flags in m_tuser.
//  - Configuration through cfg_we/cfg_addr/cfg_wdata while the block is idle.
//  - s_tready is high only in idle; one item is worked on at a time.
//  - Every divide and square root goes through one shared bit-serial unit,
//    which sets the item time; friction adds a square root and four divides
//    to an item, a biting speed limit a square root and two divides.
//  - Results sit in an output register; the next item is accepted while a
//    result waits, and a stalled receiver holds the next finished item back,
//    which keeps the input closed.
//  - Reset (synchronous, active high) loads register defaults, centres the
//    mass in the arena and zeroes the velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module point_mass_motion_step_unit #(
  parameter int FRAC_BITS = pms_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // push_x, push_y, gravity_x, gravity_y
  input  wire logic [0:0]   s_tuser,   // use_friction
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // out_pos_x, out_pos_y, out_vel_x, out_vel_y
  output logic [1:0]        m_tuser,   // bounced_x, bounced_y
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [22:0]  cfg_wdata
);

  localparam logic [63:0] HALF_W = (64'(pms_pkg::WIDTH_RST) << FRAC_BITS) >> 1;
  localparam logic [63:0] HALF_H = (64'(pms_pkg::HEIGHT_RST) << FRAC_BITS) >> 1;
  localparam logic [31:0] POS_X_RST = (HALF_W > 64'h7FFFFFFF) ? 32'h7FFFFFFF : HALF_W[31:0];
  localparam logic [31:0] POS_Y_RST = (HALF_H > 64'h7FFFFFFF) ? 32'h7FFFFFFF : HALF_H[31:0];

  // configuration
  logic [22:0] mass_value;
  logic [15:0] top_speed;
  logic [11:0] arena_width;
  logic [11:0] arena_height;
  logic [19:0] friction_coefficient;
  logic [19:0] normal_force;

  // item and motion state
  logic signed [31:0] push_x, push_y, gravity_x, gravity_y;
  logic               use_friction;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [31:0]        root;
  logic [63:0]        sum;
  logic [63:0]        prod;
  logic               comp;
  logic               bounce_x, bounce_y;

  pms_pkg::state_t     state, state_next, ret, ret_next;
  pms_pkg::arith_req_t req;
  pms_pkg::arith_rsp_t rsp;
  logic [31:0]         mul_a, mul_b;

  logic [63:0]        mass_den;
  logic signed [31:0] vel_c, acc_c;
  logic [31:0]        mag_c;
  logic               vel_c_pos;
  logic [63:0]        lim;
  logic               lim_ok;
  logic [63:0]        wall_w64, wall_h64;
  logic signed [31:0] wall_w, wall_h;
  logic               out_load;

  pms_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // shared operand terms
  always_comb begin
    mass_den  = (mass_value == '0) ? 64'd1 : 64'(mass_value);
    vel_c     = comp ? vel_y : vel_x;
    acc_c     = comp ? acc_y : acc_x;
    mag_c     = pms_pkg::mag32(vel_c);
    vel_c_pos = ~vel_c[31] && (vel_c != '0);
    lim       = 64'(top_speed) << FRAC_BITS;
    lim_ok    = (lim[63:32] == '0);
    wall_w64  = 64'(arena_width) << FRAC_BITS;
    wall_h64  = 64'(arena_height) << FRAC_BITS;
    wall_w    = (wall_w64 > 64'h7FFFFFFF) ? pms_pkg::S32_MAX : wall_w64[31:0];
    wall_h    = (wall_h64 > 64'h7FFFFFFF) ? pms_pkg::S32_MAX : wall_h64[31:0];
    out_load  = (state == pms_pkg::ST_DONE) && (!m_tvalid || m_tready);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pms_pkg::ST_IDLE;
      ret   <= pms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // next state, unit requests and multiplier operands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    s_tready   = 1'b0;
    req.start  = 1'b0;
    req.op     = pms_pkg::OP_DIV;
    req.num    = '0;
    req.den    = mass_den;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      pms_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = pms_pkg::ST_DIVX;
      end
      pms_pkg::ST_WAIT: begin
        if (rsp.done) state_next = ret;
      end
      pms_pkg::ST_DIVX: begin
        req.start  = 1'b1;
        req.num    = 64'(pms_pkg::mag32(push_x)) << FRAC_BITS;
        ret_next   = pms_pkg::ST_AX;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_AX: begin
        req.start  = 1'b1;
        req.num    = 64'(pms_pkg::mag32(push_y)) << FRAC_BITS;
        ret_next   = pms_pkg::ST_AY;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_AY: begin
        if (use_friction && (vel_x != '0 || vel_y != '0)) state_next = pms_pkg::ST_SQX;
        else state_next = pms_pkg::ST_VEL;
      end
      pms_pkg::ST_SQX: begin
        mul_a      = pms_pkg::mag32(vel_x);
        mul_b      = pms_pkg::mag32(vel_x);
        state_next = pms_pkg::ST_SQY;
      end
      pms_pkg::ST_SQY: begin
        mul_a      = pms_pkg::mag32(vel_y);
        mul_b      = pms_pkg::mag32(vel_y);
        state_next = pms_pkg::ST_SQS;
      end
      pms_pkg::ST_SQS: begin
        req.start  = 1'b1;
        req.op     = pms_pkg::OP_SQRT;
        req.num    = sum + prod;
        ret_next   = pms_pkg::ST_RFR;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_RFR: state_next = pms_pkg::ST_FU;
      pms_pkg::ST_FU: begin
        req.start  = 1'b1;
        req.num    = 64'(mag_c) << FRAC_BITS;
        req.den    = {32'b0, root};
        ret_next   = pms_pkg::ST_FMU;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_FMU: begin
        mul_a      = rsp.result[31:0];
        mul_b      = 32'(friction_coefficient);
        state_next = pms_pkg::ST_FN;
      end
      pms_pkg::ST_FN: begin
        mul_a      = prod[FRAC_BITS +: 32];
        mul_b      = 32'(normal_force);
        state_next = pms_pkg::ST_FDIV;
      end
      pms_pkg::ST_FDIV: begin
        req.start  = 1'b1;
        req.num    = (prod >> FRAC_BITS) << FRAC_BITS;
        ret_next   = pms_pkg::ST_FACC;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_FACC: begin
        state_next = comp ? pms_pkg::ST_VEL : pms_pkg::ST_FU;
      end
      pms_pkg::ST_VEL: state_next = pms_pkg::ST_LX;
      pms_pkg::ST_LX: begin
        mul_a      = pms_pkg::mag32(vel_x);
        mul_b      = pms_pkg::mag32(vel_x);
        state_next = pms_pkg::ST_LY;
      end
      pms_pkg::ST_LY: begin
        mul_a      = pms_pkg::mag32(vel_y);
        mul_b      = pms_pkg::mag32(vel_y);
        state_next = pms_pkg::ST_LL;
      end
      pms_pkg::ST_LL: begin
        mul_a      = lim[31:0];
        mul_b      = lim[31:0];
        state_next = pms_pkg::ST_LCMP;
      end
      pms_pkg::ST_LCMP: begin
        if (lim_ok && sum > prod) begin
          req.start  = 1'b1;
          req.op     = pms_pkg::OP_SQRT;
          req.num    = sum;
          ret_next   = pms_pkg::ST_RLM;
          state_next = pms_pkg::ST_WAIT;
        end else begin
          state_next = pms_pkg::ST_POS;
        end
      end
      pms_pkg::ST_RLM: state_next = pms_pkg::ST_LMUL;
      pms_pkg::ST_LMUL: begin
        mul_a      = mag_c;
        mul_b      = lim[31:0];
        state_next = pms_pkg::ST_LDIV;
      end
      pms_pkg::ST_LDIV: begin
        req.start  = 1'b1;
        req.num    = prod;
        req.den    = {32'b0, root};
        ret_next   = pms_pkg::ST_LSET;
        state_next = pms_pkg::ST_WAIT;
      end
      pms_pkg::ST_LSET: begin
        state_next = comp ? pms_pkg::ST_POS : pms_pkg::ST_LMUL;
      end
      pms_pkg::ST_POS:  state_next = pms_pkg::ST_WALL;
      pms_pkg::ST_WALL: state_next = pms_pkg::ST_DONE;
      pms_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = pms_pkg::ST_IDLE;
      end
      default: state_next = pms_pkg::ST_IDLE;
    endcase
  end

  // registered multiplier
  always_ff @(posedge clk) begin
    prod <= {32'b0, mul_a} * {32'b0, mul_b};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_value           <= pms_pkg::MASS_RST;
      top_speed            <= pms_pkg::SPEED_RST;
      arena_width          <= pms_pkg::WIDTH_RST;
      arena_height         <= pms_pkg::HEIGHT_RST;
      friction_coefficient <= pms_pkg::MU_RST;
      normal_force         <= pms_pkg::NORM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pms_pkg::CFG_MASS:   mass_value           <= cfg_wdata;
        pms_pkg::CFG_SPEED:  top_speed            <= cfg_wdata[15:0];
        pms_pkg::CFG_WIDTH:  arena_width          <= cfg_wdata[11:0];
        pms_pkg::CFG_HEIGHT: arena_height         <= cfg_wdata[11:0];
        pms_pkg::CFG_MU:     friction_coefficient <= cfg_wdata[19:0];
        pms_pkg::CFG_NORM:   normal_force         <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // motion datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= POS_X_RST;
      pos_y <= POS_Y_RST;
      vel_x <= '0;
      vel_y <= '0;
    end else begin
      case (state)
        pms_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            push_x       <= s_tdata[31:0];
            push_y       <= s_tdata[63:32];
            gravity_x    <= s_tdata[95:64];
            gravity_y    <= s_tdata[127:96];
            use_friction <= s_tuser[0];
          end
        end
        pms_pkg::ST_AX: acc_x <= pms_pkg::add_sat(
            pms_pkg::sat_div(rsp.result, push_x[31]), gravity_x);
        pms_pkg::ST_AY: acc_y <= pms_pkg::add_sat(
            pms_pkg::sat_div(rsp.result, push_y[31]), gravity_y);
        pms_pkg::ST_SQY: sum <= prod;
        pms_pkg::ST_SQS: comp <= 1'b0;
        pms_pkg::ST_RFR: root <= rsp.result[31:0];
        pms_pkg::ST_FACC: begin
          if (comp) acc_y <= pms_pkg::add_sat(acc_c, pms_pkg::sat_div(rsp.result, vel_c_pos));
          else acc_x <= pms_pkg::add_sat(acc_c, pms_pkg::sat_div(rsp.result, vel_c_pos));
          comp <= ~comp;
        end
        pms_pkg::ST_VEL: begin
          vel_x <= pms_pkg::add_sat(vel_x, acc_x);
          vel_y <= pms_pkg::add_sat(vel_y, acc_y);
        end
        pms_pkg::ST_LY: sum <= prod;
        pms_pkg::ST_LL: sum <= sum + prod;
        pms_pkg::ST_LCMP: comp <= 1'b0;
        pms_pkg::ST_RLM: root <= rsp.result[31:0];
        pms_pkg::ST_LSET: begin
          if (comp) vel_y <= vel_c[31] ? -(rsp.result[31:0]) : rsp.result[31:0];
          else vel_x <= vel_c[31] ? -(rsp.result[31:0]) : rsp.result[31:0];
          comp <= ~comp;
        end
        pms_pkg::ST_POS: begin
          pos_x <= pms_pkg::add_sat(pos_x, vel_x);
          pos_y <= pms_pkg::add_sat(pos_y, vel_y);
        end
        pms_pkg::ST_WALL: begin
          // clamp to the arena and reflect the velocity on a hit
          bounce_x <= (pos_x > wall_w) || pos_x[31];
          bounce_y <= (pos_y > wall_h) || pos_y[31];
          if (pos_x > wall_w) pos_x <= wall_w;
          else if (pos_x[31]) pos_x <= '0;
          if ((pos_x > wall_w) || pos_x[31]) vel_x <= pms_pkg::neg_sat(vel_x);
          if (pos_y > wall_h) pos_y <= wall_h;
          else if (pos_y[31]) pos_y <= '0;
          if ((pos_y > wall_h) || pos_y[31]) vel_y <= pms_pkg::neg_sat(vel_y);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {vel_y, vel_x, pos_y, pos_x};
      m_tuser  <= {bounce_y, bounce_x};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pms_checker.sv @@
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks on the motion step unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_mass_motion_step_unit_assert.svh"

module pms_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready
);

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  // a stalled result item stays offered
  `PMS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result item dropped")

  // one item at a time: input closes right after an accept
  `PMS_ASSERT_NEXT(a_in_busy, clk, rst, in_acc, !s_tready, "input open while working")

  // a result never appears in the cycle after an accept
  `PMS_ASSERT_NEXT(a_no_fast_out, clk, rst, in_acc, !$rose(m_tvalid), "result too early")

  // output empty straight after reset
  `PMS_ASSERT_SAME(a_rst_out, clk, rst, $past(rst), !m_tvalid, "output valid after reset")

endmodule

bind point_mass_motion_step_unit pms_checker u_pms_checker (.*);

`default_nettype wire
